### rtl/core/sfdd_pkg.sv
// Shared types, constants and helper functions for the stereo feedback delay.
// Used by the top level and its port checker; depends on nothing else.
`timescale 1ns / 1ps

package sfdd_pkg;

	// Sample and coefficient formats.
	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS   = 16;
	localparam int STATE_FRAC  = 6;
	localparam int WORD_BITS   = 32;

	// Shared multiplier operand and accumulator widths.
	localparam int MUL_A_BITS = 34;
	localparam int MUL_B_BITS = 18;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int SUM_BITS   = PROD_BITS + 2;

	// Configuration port.
	localparam int CFG_BITS       = 32;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_MODE     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRE_DELAY        = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DELAY            = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMP_AMOUNT      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMP_POLES       = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PING_PONG_AMOUNT = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MIX_GAINS        = 3'd7;

	// Fixed-point constants.
	localparam logic [16:0] UNITY_Q15   = 17'd32768;
	localparam logic [16:0] HALF_Q15    = 17'd16384;
	localparam logic [16:0] UNITY_COEF  = 17'd65536;
	localparam logic [15:0] FB_GAIN_MAX = 16'd32440;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ETAP_A,
		ST_ETAP_B,
		ST_PTAP_A,
		ST_PTAP_B,
		ST_MAC1,
		ST_MAC2,
		ST_MAC3,
		ST_DONE
	} state_t;

	// Operations of the shared multiply-accumulate unit.
	typedef enum logic [2:0] {
		OP_ECHO_TAP,
		OP_PING_PONG,
		OP_LOW_POLE,
		OP_BAND_POLE,
		OP_DAMP,
		OP_PRE_TAP,
		OP_FEEDBACK,
		OP_MIX
	} op_t;

	// Add half an LSB, then shift right with floor.
	function automatic logic signed [SUM_BITS-1:0] round_shift(
		input logic signed [SUM_BITS-1:0] v,
		input int                         s
	);
		logic signed [SUM_BITS-1:0] half;
		half = SUM_BITS'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// Saturate a wide value to the sample width.
	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		hi = $signed({{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	// Saturate a wide value to a signed 32-bit filter state.
	function automatic logic signed [WORD_BITS-1:0] sat_word(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		hi = $signed({{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[WORD_BITS-1:0];
		end else if (v < lo) begin
			return lo[WORD_BITS-1:0];
		end
		return v[WORD_BITS-1:0];
	endfunction

endpackage

### rtl/core/sfdd_ram.sv
// Generic single-port RAM with one write or read address per cycle and registered read data.
// Standalone; used for the echo and pre-delay sample stores.
`timescale 1ns / 1ps

module sfdd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read of the same address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/stereo_feedback_delay_damped.sv
// Top level of the stereo ping-pong feedback delay with damped feedback.
// Depends on sfdd_pkg and instantiates sfdd_ram for the echo and pre-delay stores.
`timescale 1ns / 1ps

// Usage:
// One request on the input channel carries a left and a right sample; one request
// on the output channel carries the processed frame. A request moves when valid is
// high and stall is low. in_stall is high while a frame is being worked on and
// during the clearing pass; out_valid holds its frame until the receiver takes it.
// A single shared 34x18 multiply-accumulate unit, stepping through MAC1, MAC2 and
// MAC3 for each product pair, does all arithmetic, and both stores have one port
// each. Each frame is worked on in full before the next one is accepted. A frame
// that finishes while the previous result is still stalled waits in its last step,
// and the next frame is taken only after that. Configuration writes go straight to
// the registers. After reset, and after every write of the channel mode, a clearing
// pass zeroes both stores, one entry per cycle over max(2*DELAY_DEPTH,
// 2*PRE_DELAY_DEPTH) entries (524288 at the defaults); the positions and filter
// states clear at once, and no frame is accepted until the pass ends.

module stereo_feedback_delay_damped #(
	parameter int DELAY_DEPTH     = 262144,
	parameter int PRE_DELAY_DEPTH = 8192
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [sfdd_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [sfdd_pkg::CFG_BITS-1:0]              cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0]    left_in,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0]    right_in,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [sfdd_pkg::SAMPLE_BITS-1:0]    left_out,
	output logic signed [sfdd_pkg::SAMPLE_BITS-1:0]    right_out
);

	localparam int SB        = sfdd_pkg::SAMPLE_BITS;
	localparam int PW        = $clog2(DELAY_DEPTH);
	localparam int EW        = $clog2(2 * DELAY_DEPTH);
	localparam int PPW       = $clog2(PRE_DELAY_DEPTH);
	localparam int PEW       = $clog2(2 * PRE_DELAY_DEPTH);
	localparam int CLR_DEPTH = (DELAY_DEPTH > PRE_DELAY_DEPTH) ?
		2 * DELAY_DEPTH : 2 * PRE_DELAY_DEPTH;
	localparam int CW        = $clog2(CLR_DEPTH);
	localparam logic [31:0] DLY_MAX = 32'((DELAY_DEPTH - 1) * 256);
	localparam logic [31:0] PRE_MAX = 32'((PRE_DELAY_DEPTH - 1) * 256);

	// Configuration registers.
	logic        mode_q;
	logic [20:0] pre_dly_q;
	logic [25:0] dly_q;
	logic [15:0] damp_q;
	logic [31:0] poles_q;
	logic [14:0] fbg_q;
	logic [15:0] pp_q;
	logic [31:0] mix_q;

	// Sequencer state.
	sfdd_pkg::state_t state_q, state_d;
	sfdd_pkg::op_t    op_q, op_d;
	logic             ch_q, ch_d;
	logic [CW-1:0]    clr_q;
	logic [PW-1:0]    epos_q;
	logic [PPW-1:0]   ppos_q;

	// Per-frame working registers.
	logic signed [SB-1:0]   x_q   [2];
	logic signed [SB-1:0]   wet_q [2];
	logic signed [SB:0]     fb_q  [2];
	logic signed [31:0]     lp_q  [2];
	logic signed [31:0]     bp_q  [2];
	logic signed [27:0]     dmp_q [2];
	logic signed [SB-1:0]   y_q   [2];
	logic signed [SB-1:0]   ha_q;
	logic signed [SB-1:0]   pre_q;
	logic signed [sfdd_pkg::PROD_BITS-1:0] prod_q;
	logic signed [sfdd_pkg::PROD_BITS-1:0] acc_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   left_out_q;
	logic signed [SB-1:0]   right_out_q;

	// Clamped settings.
	logic [31:0]    dly_ext, pre_ext, dly_c, pre_c;
	logic [PW-1:0]  ei;
	logic [7:0]     ef;
	logic [PPW-1:0] pi;
	logic [7:0]     pf;
	logic [15:0]    gain_c;
	logic [16:0]    pp_c, pp_a, pp_inv, damp_c;
	logic [16:0]    plo_inv, phi_inv;
	logic           pp_low;

	// Store ports.
	logic           e_we, p_we;
	logic [EW-1:0]  e_addr;
	logic [PEW-1:0] p_addr;
	logic [SB-1:0]  e_wdata, p_wdata, e_rdata, p_rdata;
	logic signed [SB-1:0] e_rd, p_rd;

	// Tap address arithmetic.
	logic [PW-1:0]  ek, eidx;
	logic [PW:0]    eidx_sum;
	logic [PPW-1:0] pk, pidx;
	logic [PPW:0]   pidx_sum;
	logic [EW-1:0]  e_base;
	logic [PEW-1:0] p_base;

	// Multiply-accumulate operands and result.
	logic signed [sfdd_pkg::MUL_A_BITS-1:0] a1, a2, mul_a;
	logic signed [sfdd_pkg::MUL_B_BITS-1:0] b1, b2, mul_b;
	logic signed [sfdd_pkg::SUM_BITS-1:0]   sum_raw, rounded, addend, mac_res;
	logic signed [SB:0]   tap_diff_e, tap_diff_p, pp_sum, l2, r2;
	logic signed [30:0]   xs;
	logic signed [32:0]   xs_minus_lp;
	logic                 stereo, accept, out_free, mode_wr;

	assign stereo   = mode_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign mode_wr  = cfg_we && (cfg_index == sfdd_pkg::REG_CHANNEL_MODE);

	// Clamp the delay lengths, gains and amounts.
	assign dly_ext = 32'(dly_q);
	assign pre_ext = 32'(pre_dly_q);
	always_comb begin
		dly_c = dly_ext;
		if (dly_ext < 32'd256) begin
			dly_c = 32'd256;
		end else if (dly_ext > DLY_MAX) begin
			dly_c = DLY_MAX;
		end
		pre_c = (pre_ext > PRE_MAX) ? PRE_MAX : pre_ext;
	end
	assign ei = dly_c[8 +: PW];
	assign ef = dly_c[7:0];
	assign pi = pre_c[8 +: PPW];
	assign pf = pre_c[7:0];

	always_comb begin
		gain_c  = ({1'b0, fbg_q} > sfdd_pkg::FB_GAIN_MAX) ? sfdd_pkg::FB_GAIN_MAX : {1'b0, fbg_q};
		pp_c    = ({1'b0, pp_q} > sfdd_pkg::UNITY_Q15) ? sfdd_pkg::UNITY_Q15 : {1'b0, pp_q};
		damp_c  = ({1'b0, damp_q} > sfdd_pkg::UNITY_Q15) ? sfdd_pkg::UNITY_Q15 : {1'b0, damp_q};
		pp_low  = (pp_c <= sfdd_pkg::HALF_Q15);
		pp_a    = pp_low ? {pp_c[15:0], 1'b0} : {(pp_c[15:0] - sfdd_pkg::HALF_Q15[15:0]), 1'b0};
		pp_inv  = sfdd_pkg::UNITY_Q15 - pp_a;
		plo_inv = sfdd_pkg::UNITY_COEF - {1'b0, poles_q[15:0]};
		phi_inv = sfdd_pkg::UNITY_COEF - {1'b0, poles_q[31:16]};
	end

	// History addresses: k frames back from the write position, wrapped once.
	always_comb begin
		ek       = (state_q == sfdd_pkg::ST_ETAP_A) ? (ei - 1'b1) : ei;
		eidx_sum = {1'b0, epos_q} + (PW + 1)'(DELAY_DEPTH - 1) - {1'b0, ek};
		eidx     = (eidx_sum >= (PW + 1)'(DELAY_DEPTH)) ?
			PW'(eidx_sum - (PW + 1)'(DELAY_DEPTH)) : eidx_sum[PW-1:0];
		pk       = (state_q == sfdd_pkg::ST_PTAP_A) ? (pi - 1'b1) : pi;
		pidx_sum = {1'b0, ppos_q} + (PPW + 1)'(PRE_DELAY_DEPTH - 1) - {1'b0, pk};
		pidx     = (pidx_sum >= (PPW + 1)'(PRE_DELAY_DEPTH)) ?
			PPW'(pidx_sum - (PPW + 1)'(PRE_DELAY_DEPTH)) : pidx_sum[PPW-1:0];
		e_base   = ch_q ? EW'(DELAY_DEPTH) : '0;
		p_base   = ch_q ? PEW'(PRE_DELAY_DEPTH) : '0;
	end

	assign e_rd = $signed(e_rdata);
	assign p_rd = $signed(p_rdata);

	// Operand selection for the shared multiply-accumulate unit.
	always_comb begin
		tap_diff_e  = {e_rd[SB-1], e_rd} - {ha_q[SB-1], ha_q};
		tap_diff_p  = {p_rd[SB-1], p_rd} - {ha_q[SB-1], ha_q};
		l2          = {wet_q[0], 1'b0};
		r2          = {wet_q[1], 1'b0};
		pp_sum      = {wet_q[0][SB-1], wet_q[0]} + {wet_q[1][SB-1], wet_q[1]};
		xs          = {fb_q[ch_q], 6'b0};
		xs_minus_lp = 33'(xs) - 33'(lp_q[ch_q]);
		a1     = '0;
		b1     = '0;
		a2     = '0;
		b2     = '0;
		addend = '0;
		rounded = '0;
		sum_raw = sfdd_pkg::SUM_BITS'(acc_q) + sfdd_pkg::SUM_BITS'(prod_q);
		case (op_q)
			sfdd_pkg::OP_ECHO_TAP: begin
				a1      = sfdd_pkg::MUL_A_BITS'(tap_diff_e);
				b1      = $signed({10'b0, ef});
				addend  = sfdd_pkg::SUM_BITS'(ha_q);
				rounded = sfdd_pkg::round_shift(sum_raw, 8);
			end
			sfdd_pkg::OP_PRE_TAP: begin
				a1      = sfdd_pkg::MUL_A_BITS'(tap_diff_p);
				b1      = $signed({10'b0, pf});
				addend  = sfdd_pkg::SUM_BITS'(ha_q);
				rounded = sfdd_pkg::round_shift(sum_raw, 8);
			end
			sfdd_pkg::OP_PING_PONG: begin
				b1 = $signed({1'b0, pp_inv});
				b2 = $signed({1'b0, pp_a});
				if (pp_low) begin
					a1 = sfdd_pkg::MUL_A_BITS'(ch_q ? r2 : l2);
					a2 = sfdd_pkg::MUL_A_BITS'(pp_sum);
				end else begin
					a1 = sfdd_pkg::MUL_A_BITS'(pp_sum);
					a2 = sfdd_pkg::MUL_A_BITS'(ch_q ? l2 : r2);
				end
				rounded = sfdd_pkg::round_shift(sum_raw, 16);
			end
			sfdd_pkg::OP_LOW_POLE: begin
				a1      = sfdd_pkg::MUL_A_BITS'(xs);
				b1      = $signed({1'b0, plo_inv});
				a2      = sfdd_pkg::MUL_A_BITS'(lp_q[ch_q]);
				b2      = $signed({2'b0, poles_q[15:0]});
				rounded = sfdd_pkg::round_shift(sum_raw, sfdd_pkg::COEF_BITS);
			end
			sfdd_pkg::OP_BAND_POLE: begin
				a1      = sfdd_pkg::MUL_A_BITS'(xs_minus_lp);
				b1      = $signed({1'b0, phi_inv});
				a2      = sfdd_pkg::MUL_A_BITS'(bp_q[ch_q]);
				b2      = $signed({2'b0, poles_q[31:16]});
				rounded = sfdd_pkg::round_shift(sum_raw, sfdd_pkg::COEF_BITS);
			end
			sfdd_pkg::OP_DAMP: begin
				a1      = sfdd_pkg::MUL_A_BITS'(xs);
				b1      = $signed({1'b0, sfdd_pkg::UNITY_Q15 - damp_c});
				a2      = sfdd_pkg::MUL_A_BITS'(bp_q[ch_q]);
				b2      = $signed({1'b0, damp_c});
				rounded = sfdd_pkg::round_shift(sum_raw, 15 + sfdd_pkg::STATE_FRAC);
			end
			sfdd_pkg::OP_FEEDBACK: begin
				a1      = sfdd_pkg::MUL_A_BITS'(dmp_q[ch_q]);
				b1      = $signed({2'b0, gain_c});
				addend  = sfdd_pkg::SUM_BITS'(pre_q);
				rounded = sfdd_pkg::round_shift(sum_raw, 15);
			end
			sfdd_pkg::OP_MIX: begin
				a1      = sfdd_pkg::MUL_A_BITS'(x_q[ch_q]);
				b1      = $signed({2'b0, mix_q[15:0]});
				a2      = sfdd_pkg::MUL_A_BITS'(wet_q[ch_q]);
				b2      = $signed({2'b0, mix_q[31:16]});
				rounded = sfdd_pkg::round_shift(sum_raw, 15);
			end
			default: begin
				rounded = sum_raw;
			end
		endcase
		mul_a   = (state_q == sfdd_pkg::ST_MAC2) ? a2 : a1;
		mul_b   = (state_q == sfdd_pkg::ST_MAC2) ? b2 : b1;
		mac_res = rounded + addend;
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		ch_d    = ch_q;
		case (state_q)
			sfdd_pkg::ST_CLEAR: begin
				if (clr_q == CW'(CLR_DEPTH - 1)) begin
					state_d = sfdd_pkg::ST_IDLE;
				end
			end
			sfdd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sfdd_pkg::ST_ETAP_A;
					ch_d    = 1'b0;
				end
			end
			sfdd_pkg::ST_ETAP_A: state_d = sfdd_pkg::ST_ETAP_B;
			sfdd_pkg::ST_ETAP_B: begin
				state_d = sfdd_pkg::ST_MAC1;
				op_d    = sfdd_pkg::OP_ECHO_TAP;
			end
			sfdd_pkg::ST_PTAP_A: state_d = sfdd_pkg::ST_PTAP_B;
			sfdd_pkg::ST_PTAP_B: begin
				state_d = sfdd_pkg::ST_MAC1;
				op_d    = sfdd_pkg::OP_PRE_TAP;
			end
			sfdd_pkg::ST_MAC1: state_d = sfdd_pkg::ST_MAC2;
			sfdd_pkg::ST_MAC2: state_d = sfdd_pkg::ST_MAC3;
			sfdd_pkg::ST_MAC3: begin
				state_d = sfdd_pkg::ST_MAC1;
				case (op_q)
					sfdd_pkg::OP_ECHO_TAP: begin
						if (stereo && !ch_q) begin
							ch_d    = 1'b1;
							state_d = sfdd_pkg::ST_ETAP_A;
						end else begin
							ch_d = 1'b0;
							op_d = stereo ? sfdd_pkg::OP_PING_PONG : sfdd_pkg::OP_LOW_POLE;
						end
					end
					sfdd_pkg::OP_PING_PONG: begin
						if (!ch_q) begin
							ch_d = 1'b1;
						end else begin
							ch_d = 1'b0;
							op_d = sfdd_pkg::OP_LOW_POLE;
						end
					end
					sfdd_pkg::OP_LOW_POLE: op_d = sfdd_pkg::OP_BAND_POLE;
					sfdd_pkg::OP_BAND_POLE: op_d = sfdd_pkg::OP_DAMP;
					sfdd_pkg::OP_DAMP: begin
						if (stereo && !ch_q) begin
							ch_d = 1'b1;
							op_d = sfdd_pkg::OP_LOW_POLE;
						end else begin
							ch_d    = 1'b0;
							state_d = sfdd_pkg::ST_PTAP_A;
						end
					end
					sfdd_pkg::OP_PRE_TAP: op_d = sfdd_pkg::OP_FEEDBACK;
					sfdd_pkg::OP_FEEDBACK: op_d = sfdd_pkg::OP_MIX;
					sfdd_pkg::OP_MIX: begin
						if (stereo && !ch_q) begin
							ch_d    = 1'b1;
							state_d = sfdd_pkg::ST_PTAP_A;
						end else begin
							state_d = sfdd_pkg::ST_DONE;
						end
					end
					default: state_d = sfdd_pkg::ST_IDLE;
				endcase
			end
			sfdd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sfdd_pkg::ST_IDLE;
				end
			end
			default: state_d = sfdd_pkg::ST_IDLE;
		endcase
		if (mode_wr) begin
			state_d = sfdd_pkg::ST_CLEAR;
		end
	end

	// Store port control and handshake outputs.
	always_comb begin
		e_we    = 1'b0;
		p_we    = 1'b0;
		e_addr  = EW'(eidx) + e_base;
		p_addr  = PEW'(pidx) + p_base;
		e_wdata = '0;
		p_wdata = '0;
		case (state_q)
			sfdd_pkg::ST_CLEAR: begin
				e_we   = (32'(clr_q) < 32'(2 * DELAY_DEPTH));
				p_we   = (32'(clr_q) < 32'(2 * PRE_DELAY_DEPTH));
				e_addr = EW'(clr_q);
				p_addr = PEW'(clr_q);
			end
			sfdd_pkg::ST_MAC3: begin
				if (op_q == sfdd_pkg::OP_FEEDBACK) begin
					e_we    = 1'b1;
					p_we    = 1'b1;
					e_addr  = EW'(epos_q) + e_base;
					p_addr  = PEW'(ppos_q) + p_base;
					e_wdata = sfdd_pkg::sat_sample(mac_res);
					p_wdata = x_q[ch_q];
				end
			end
			default: begin
				e_we = 1'b0;
			end
		endcase
	end

	assign in_stall  = (state_q != sfdd_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// Control registers, configuration, positions and filter states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfdd_pkg::ST_CLEAR;
			op_q        <= sfdd_pkg::OP_ECHO_TAP;
			ch_q        <= 1'b0;
			clr_q       <= '0;
			epos_q      <= '0;
			ppos_q      <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= 1'b1;
			pre_dly_q   <= '0;
			dly_q       <= 26'd256;
			damp_q      <= '0;
			poles_q     <= '0;
			fbg_q       <= '0;
			pp_q        <= '0;
			mix_q       <= 32'd32768;
			lp_q[0]     <= '0;
			lp_q[1]     <= '0;
			bp_q[0]     <= '0;
			bp_q[1]     <= '0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ch_q    <= ch_d;

			if (state_q == sfdd_pkg::ST_CLEAR && !mode_wr) begin
				clr_q <= clr_q + 1'b1;
			end

			// Filter state updates.
			if (state_q == sfdd_pkg::ST_MAC3 && op_q == sfdd_pkg::OP_LOW_POLE) begin
				lp_q[ch_q] <= sfdd_pkg::sat_word(mac_res);
			end
			if (state_q == sfdd_pkg::ST_MAC3 && op_q == sfdd_pkg::OP_BAND_POLE) begin
				bp_q[ch_q] <= sfdd_pkg::sat_word(mac_res);
			end

			// Output register and position advance.
			if (state_q == sfdd_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				epos_q      <= (epos_q == PW'(DELAY_DEPTH - 1)) ? '0 : epos_q + 1'b1;
				ppos_q      <= (ppos_q == PPW'(PRE_DELAY_DEPTH - 1)) ? '0 : ppos_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Configuration writes; a mode write restarts the clearing pass.
			if (cfg_we) begin
				case (cfg_index)
					sfdd_pkg::REG_CHANNEL_MODE: begin
						mode_q  <= cfg_data[0];
						clr_q   <= '0;
						epos_q  <= '0;
						ppos_q  <= '0;
						lp_q[0] <= '0;
						lp_q[1] <= '0;
						bp_q[0] <= '0;
						bp_q[1] <= '0;
					end
					sfdd_pkg::REG_PRE_DELAY:        pre_dly_q <= cfg_data[20:0];
					sfdd_pkg::REG_DELAY:            dly_q     <= cfg_data[25:0];
					sfdd_pkg::REG_DAMP_AMOUNT:      damp_q    <= cfg_data[15:0];
					sfdd_pkg::REG_DAMP_POLES:       poles_q   <= cfg_data;
					sfdd_pkg::REG_FEEDBACK_GAIN:    fbg_q     <= cfg_data[14:0];
					sfdd_pkg::REG_PING_PONG_AMOUNT: pp_q      <= cfg_data[15:0];
					sfdd_pkg::REG_MIX_GAINS:        mix_q     <= cfg_data;
					default: mix_q <= mix_q;
				endcase
			end
		end
	end

	// Datapath registers of the multiply-accumulate unit and per-frame values.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q[0] <= left_in;
			x_q[1] <= right_in;
		end
		if (state_q == sfdd_pkg::ST_ETAP_B) begin
			ha_q <= e_rd;
		end
		if (state_q == sfdd_pkg::ST_PTAP_B) begin
			ha_q <= (pi == '0) ? x_q[ch_q] : p_rd;
		end
		if (state_q == sfdd_pkg::ST_MAC1) begin
			prod_q <= mul_a * mul_b;
			acc_q  <= '0;
		end
		if (state_q == sfdd_pkg::ST_MAC2) begin
			acc_q  <= prod_q;
			prod_q <= mul_a * mul_b;
		end
		if (state_q == sfdd_pkg::ST_MAC3) begin
			case (op_q)
				sfdd_pkg::OP_ECHO_TAP: begin
					wet_q[ch_q] <= mac_res[SB-1:0];
					fb_q[ch_q]  <= mac_res[SB:0];
				end
				sfdd_pkg::OP_PING_PONG: fb_q[ch_q]  <= mac_res[SB:0];
				sfdd_pkg::OP_DAMP:      dmp_q[ch_q] <= mac_res[27:0];
				sfdd_pkg::OP_PRE_TAP:   pre_q       <= mac_res[SB-1:0];
				sfdd_pkg::OP_MIX:       y_q[ch_q]   <= sfdd_pkg::sat_sample(mac_res);
				default:                pre_q       <= pre_q;
			endcase
		end
		if (state_q == sfdd_pkg::ST_DONE && out_free) begin
			left_out_q  <= y_q[0];
			right_out_q <= stereo ? y_q[1] : '0;
		end
	end

	// Echo store: two lines of DELAY_DEPTH samples, left then right.
	sfdd_ram #(
		.WIDTH(SB),
		.DEPTH(2 * DELAY_DEPTH)
	) u_echo_ram (
		.clk  (clk),
		.we   (e_we),
		.addr (e_addr),
		.wdata(e_wdata),
		.rdata(e_rdata)
	);

	// Pre-delay store: two lines of PRE_DELAY_DEPTH samples, left then right.
	sfdd_ram #(
		.WIDTH(SB),
		.DEPTH(2 * PRE_DELAY_DEPTH)
	) u_pre_ram (
		.clk  (clk),
		.we   (p_we),
		.addr (p_addr),
		.wdata(p_wdata),
		.rdata(p_rdata)
	);

endmodule

### rtl/core/sfdd_checker.sv
// Port-level checker for the stereo feedback delay, bound to the top level.
// Depends on sfdd_pkg for the sample width.
`timescale 1ns / 1ps

module sfdd_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_valid,
	input logic                                    in_stall,
	input logic                                    out_valid,
	input logic                                    out_stall,
	input logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left_out,
	input logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right_out
);

	// A stalled result stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(right_out))
		else $error("stalled result changed");

	// The block works on one frame at a time, so an accepted request closes the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while a frame is in work");

	// A new result only appears after the block has been busy with a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	// The clearing pass after reset keeps the input closed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall)
		else $error("input open during clearing pass");

endmodule

bind stereo_feedback_delay_damped sfdd_checker u_sfdd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.left_out (left_out),
	.right_out(right_out)
);

### verif/stereo_feedback_delay_damped_checker.sv
// Channel checker for the stereo feedback delay: watches the configuration port and both
// request channels, predicts each output frame and compares it. Depends on sfdd_pkg.
`timescale 1ns / 1ps

module stereo_feedback_delay_damped_checker #(
	parameter int DELAY_DEPTH     = 262144,
	parameter int PRE_DELAY_DEPTH = 8192
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [sfdd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [sfdd_pkg::CFG_BITS-1:0]           cfg_data,
	input  logic                                    in_valid,
	input  logic                                    in_stall,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right_in,
	input  logic                                    out_valid,
	input  logic                                    out_stall,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left_out,
	input  logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right_out,
	output int                                      errors,
	output int                                      pending
);

	typedef struct {
		logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left;
		logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right;
	} frame_t;

	// Register copies.
	logic        stereo;
	logic [20:0] pre_len;
	logic [25:0] echo_len;
	logic [15:0] damp_amt;
	logic [31:0] poles;
	logic [14:0] fb_gain;
	logic [15:0] pp_amt;
	logic [31:0] gains;

	// Model state.
	int          echo_mem [2][DELAY_DEPTH];
	int          pre_mem [2][PRE_DELAY_DEPTH];
	int unsigned echo_pos;
	int unsigned pre_pos;
	longint      low_st [2];
	longint      band_st [2];

	frame_t frames_due[$];

	assign pending = frames_due.size();

	function automatic longint rnd(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	// Sample k frames back in one line; k of -1 is the current input.
	function automatic longint line_at(bit use_echo, int ch, longint k, longint cur);
		longint depth;
		longint pos;
		if (k < 0) begin
			return cur;
		end
		depth = use_echo ? DELAY_DEPTH : PRE_DELAY_DEPTH;
		pos = use_echo ? echo_pos : pre_pos;
		return use_echo ? echo_mem[ch][(pos + depth - 1 - k) % depth]
			: pre_mem[ch][(pos + depth - 1 - k) % depth];
	endfunction

	// Linear interpolation between two neighbors at a delay with 8 fraction bits.
	function automatic longint frac_tap(bit use_echo, int ch, longint d, longint cur);
		longint a;
		longint b;
		a = line_at(use_echo, ch, (d >>> 8) - 1, cur);
		b = line_at(use_echo, ch, d >>> 8, cur);
		return a + rnd((b - a) * (d & 255), 8);
	endfunction

	function automatic longint pole(longint x, longint y, longint p);
		return clip(rnd((65536 - p) * x + p * y, sfdd_pkg::COEF_BITS), 32);
	endfunction

	// Two cascaded one-pole sections, then a blend toward the band signal.
	function automatic longint damped(int ch, longint x);
		longint plo;
		longint phi;
		longint d;
		longint xs;
		plo = poles[15:0];
		phi = poles[31:16];
		d = damp_amt > 32768 ? 32768 : damp_amt;
		xs = x * 64;
		low_st[ch] = pole(xs, low_st[ch], plo);
		band_st[ch] = pole(xs - low_st[ch], band_st[ch], phi);
		return rnd(xs * (32768 - d) + band_st[ch] * d, 15 + sfdd_pkg::STATE_FRAC);
	endfunction

	function automatic void clear_all();
		foreach (echo_mem[c, k]) echo_mem[c][k] = 0;
		foreach (pre_mem[c, k]) pre_mem[c][k] = 0;
		echo_pos = 0;
		pre_pos = 0;
		low_st = '{0, 0};
		band_st = '{0, 0};
	endfunction

	// Work out one output frame and advance the model state.
	function automatic frame_t process_frame(longint lx, longint rx);
		longint x [2];
		longint wet [2];
		longint fb [2];
		longint dmp [2];
		longint dp;
		longint dd;
		longint g;
		longint pp;
		longint a;
		longint inv;
		longint s;
		longint pre;
		longint w;
		longint y [2];
		int nch;
		frame_t r;
		x = '{lx, rx};
		wet = '{0, 0};
		y = '{0, 0};
		nch = stereo ? 2 : 1;
		dp = pre_len;
		if (dp > longint'(PRE_DELAY_DEPTH - 1) * 256) dp = longint'(PRE_DELAY_DEPTH - 1) * 256;
		dd = echo_len;
		if (dd < 256) dd = 256;
		if (dd > longint'(DELAY_DEPTH - 1) * 256) dd = longint'(DELAY_DEPTH - 1) * 256;
		g = fb_gain > 32440 ? 32440 : fb_gain;
		pp = pp_amt > 32768 ? 32768 : pp_amt;
		for (int ch = 0; ch < nch; ch++) begin
			wet[ch] = frac_tap(1'b1, ch, dd, 0);
		end
		// Ping-pong cross blend of the two taps.
		if (stereo) begin
			s = wet[0] + wet[1];
			if (pp <= 16384) begin
				a = 2 * pp;
				inv = 32768 - a;
				fb[0] = rnd(2 * wet[0] * inv + s * a, 16);
				fb[1] = rnd(2 * wet[1] * inv + s * a, 16);
			end else begin
				a = 2 * (pp - 16384);
				inv = 32768 - a;
				fb[0] = rnd(s * inv + 2 * wet[1] * a, 16);
				fb[1] = rnd(s * inv + 2 * wet[0] * a, 16);
			end
		end else begin
			fb[0] = wet[0];
		end
		for (int ch = 0; ch < nch; ch++) begin
			dmp[ch] = damped(ch, fb[ch]);
		end
		// Write back and mix.
		for (int ch = 0; ch < nch; ch++) begin
			pre = frac_tap(1'b0, ch, dp, x[ch]);
			w = pre + rnd(dmp[ch] * g, 15);
			y[ch] = clip(rnd(x[ch] * gains[15:0] + wet[ch] * gains[31:16], 15),
				sfdd_pkg::SAMPLE_BITS);
			pre_mem[ch][pre_pos] = int'(x[ch]);
			echo_mem[ch][echo_pos] = int'(clip(w, sfdd_pkg::SAMPLE_BITS));
		end
		pre_pos = (pre_pos + 1) % PRE_DELAY_DEPTH;
		echo_pos = (echo_pos + 1) % DELAY_DEPTH;
		r.left = y[0][sfdd_pkg::SAMPLE_BITS-1:0];
		r.right = y[1][sfdd_pkg::SAMPLE_BITS-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Follow the configuration, check results, then predict new requests.
	always @(posedge clk or negedge arst_n) begin
		frame_t want;
		if (!arst_n) begin
			stereo = 1'b1;
			pre_len = '0;
			echo_len = 26'd256;
			damp_amt = '0;
			poles = '0;
			fb_gain = '0;
			pp_amt = '0;
			gains = 32'd32768;
			errors = 0;
			frames_due.delete();
			clear_all();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfdd_pkg::REG_CHANNEL_MODE: begin
						stereo = cfg_data[0];
						clear_all();
					end
					sfdd_pkg::REG_PRE_DELAY: pre_len = cfg_data[20:0];
					sfdd_pkg::REG_DELAY: echo_len = cfg_data[25:0];
					sfdd_pkg::REG_DAMP_AMOUNT: damp_amt = cfg_data[15:0];
					sfdd_pkg::REG_DAMP_POLES: poles = cfg_data;
					sfdd_pkg::REG_FEEDBACK_GAIN: fb_gain = cfg_data[14:0];
					sfdd_pkg::REG_PING_PONG_AMOUNT: pp_amt = cfg_data[15:0];
					sfdd_pkg::REG_MIX_GAINS: gains = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					report_mismatch("unexpected output request", 1, 0);
				end else begin
					want = frames_due.pop_front();
					if (left_out !== want.left) begin
						report_mismatch("left_out", left_out, want.left);
					end
					if (right_out !== want.right) begin
						report_mismatch("right_out", right_out, want.right);
					end
				end
			end
			if (in_valid && !in_stall) begin
				frames_due.push_back(process_frame(left_in, right_in));
			end
		end
	end

endmodule

### verif/stereo_feedback_delay_damped_test.sv
// Testbench top for the stereo feedback delay: drives configuration and input frames
// with random idling and stalls, and gives the verdict. Depends on sfdd_pkg and the checker.
`timescale 1ns / 1ps

module stereo_feedback_delay_damped_test;

	logic                                    clk;
	logic                                    arst_n;
	logic                                    cfg_we;
	logic [sfdd_pkg::CFG_INDEX_BITS-1:0]     cfg_index;
	logic [sfdd_pkg::CFG_BITS-1:0]           cfg_data;
	logic                                    in_valid;
	logic                                    in_stall;
	logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left_in;
	logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right_in;
	logic                                    out_valid;
	logic                                    out_stall;
	logic signed [sfdd_pkg::SAMPLE_BITS-1:0] left_out;
	logic signed [sfdd_pkg::SAMPLE_BITS-1:0] right_out;
	int                                      errors;
	int                                      pending;

	int send_idle_pct;
	int recv_stall_pct;
	int taken_count;
	int hold_left;

	stereo_feedback_delay_damped u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.left_in(left_in), .right_in(right_in), .out_valid(out_valid),
		.out_stall(out_stall), .left_out(left_out), .right_out(right_out)
	);

	stereo_feedback_delay_damped_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.left_in(left_in), .right_in(right_in), .out_valid(out_valid),
		.out_stall(out_stall), .left_out(left_out), .right_out(right_out),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Receiver: random stalls, plus one long hold-off after a few hundred frames.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			taken_count <= 0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				taken_count <= taken_count + 1;
			end
			if (taken_count == 400 && out_valid && !out_stall) begin
				hold_left <= 600;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < recv_stall_pct;
			end
		end
	end

	// Offer one frame after a random idle gap and wait until it is taken.
	task automatic send_frame(logic [23:0] l, logic [23:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Keeps the write enable high; the caller lowers it after a batch.
	task automatic write_reg(logic [sfdd_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// One random setting; delays are mostly short so the feedback path stays busy.
	task automatic random_setting();
		write_reg(sfdd_pkg::REG_PRE_DELAY,
			$urandom_range(3) == 0 ? 32'h1FFFFF : $urandom_range(0, 5000));
		write_reg(sfdd_pkg::REG_DELAY,
			$urandom_range(5) == 0 ? 32'h3FFFFFF : $urandom_range(0, 9000));
		write_reg(sfdd_pkg::REG_DAMP_AMOUNT, $urandom_range(65535));
		write_reg(sfdd_pkg::REG_DAMP_POLES, $urandom);
		write_reg(sfdd_pkg::REG_FEEDBACK_GAIN, $urandom_range(32767));
		write_reg(sfdd_pkg::REG_PING_PONG_AMOUNT, $urandom_range(65535));
		write_reg(sfdd_pkg::REG_MIX_GAINS, $urandom);
		cfg_we <= 1'b0;
	endtask

	task automatic random_frames(int count);
		for (int k = 0; k < count; k++) begin
			send_idle_pct = k < count / 3 ? 27 : (k < 2 * count / 3 ? 73 : 0);
			recv_stall_pct = k < count / 3 ? 73 : (k < 2 * count / 3 ? 27 : 0);
			send_frame(24'($urandom), 24'($urandom));
		end
	endtask

	initial begin
		logic [23:0] edge_vals [7];
		edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF, 24'h000001,
			24'h555555, 24'hAAAAAA};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: loud feedback, out-of-range controls clamped, full gains saturate.
		write_reg(sfdd_pkg::REG_DELAY, 32'd0);
		write_reg(sfdd_pkg::REG_FEEDBACK_GAIN, 32'h7FFF);
		write_reg(sfdd_pkg::REG_DAMP_AMOUNT, 32'hFFFF);
		write_reg(sfdd_pkg::REG_DAMP_POLES, 32'hFFFF_FFFF);
		write_reg(sfdd_pkg::REG_PING_PONG_AMOUNT, 32'hFFFF);
		write_reg(sfdd_pkg::REG_MIX_GAINS, 32'hFFFF_FFFF);
		cfg_we <= 1'b0;
		foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[6 - i]);
		drain();
		// Zero pre-delay versus clamped long pre-delay, half ping-pong, unity mix.
		write_reg(sfdd_pkg::REG_PRE_DELAY, 32'h1FFFFF);
		write_reg(sfdd_pkg::REG_DELAY, 32'd384);
		write_reg(sfdd_pkg::REG_PING_PONG_AMOUNT, 32'd16384);
		write_reg(sfdd_pkg::REG_DAMP_POLES, 32'h0000_0000);
		write_reg(sfdd_pkg::REG_MIX_GAINS, 32'h8000_8000);
		cfg_we <= 1'b0;
		foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[i]);
		drain();

		// Random stereo phases.
		for (int p = 0; p < 4; p++) begin
			random_setting();
			random_frames(300);
			drain();
		end

		// Mono phase; the mode write clears all state.
		write_reg(sfdd_pkg::REG_CHANNEL_MODE, 32'd0);
		cfg_we <= 1'b0;
		random_setting();
		random_frames(300);
		drain();

		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog well beyond two clearing passes and all frames.
	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
